// ===== hw/rtl/prat_pkg.sv =====
// Package with the types, codes and sizes shared by the page range translator.
`default_nettype none

package prat_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int PAGE_BITS     = 12;

    localparam int ADDR_W = 32;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  count_t;

    localparam addr_t PAGE_OFFS_MASK = addr_t'((64'(1) << PAGE_BITS) - 64'(1));
    localparam addr_t PAGE_MASK      = ~PAGE_OFFS_MASK;

    localparam logic [1:0] ACT_MAP   = 2'd0;
    localparam logic [1:0] ACT_UNMAP = 2'd1;
    localparam logic [1:0] ACT_V2P   = 2'd2;
    localparam logic [1:0] ACT_P2V   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        addr_t      virt_addr;
        addr_t      phys_addr;
        addr_t      length;
    } in_item_t;

    typedef struct packed {
        addr_t      result_addr;
        logic       hit;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        addr_t vbase;
        addr_t pbase;
        addr_t len;
    } entry_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic   shift_en;
        logic   capture;
        logic   fwd;
        addr_t  lookup;
        addr_t  key_vb;
        addr_t  key_len;
        entry_t new_entry;
    } cell_ctrl_t;

    // Priority select chain passed from cell to cell.
    typedef struct packed {
        logic  found;
        addr_t to;
        addr_t off;
    } sel_t;

endpackage

`default_nettype wire

// ===== hw/rtl/prat_in_if.sv =====
// Request channel interface carrying one input item per transfer.
`default_nettype none

interface prat_in_if;
    import prat_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/prat_out_if.sv =====
// Response channel interface carrying one result item per transfer.
`default_nettype none

interface prat_out_if;
    import prat_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/prat_cell.sv =====
// One table cell: holds one range, matches it, shifts from its right neighbor.
`default_nettype none

module prat_cell (
    input  wire logic                 clk,
    input  wire prat_pkg::cell_ctrl_t ctrl,
    input  wire logic                 valid,
    input  wire logic                 load,
    input  wire prat_pkg::entry_t     neighbor_in,
    output      prat_pkg::entry_t     entry_out,
    input  wire logic                 shift_in,
    output      logic                 shift_out,
    input  wire prat_pkg::sel_t       sel_in,
    output      prat_pkg::sel_t       sel_out
);
    import prat_pkg::*;

    entry_t entry_reg, entry_next;
    logic   hit_reg, hit_next;
    addr_t  off_reg, off_next;
    addr_t  to_reg, to_next;
    logic   matched;
    addr_t  from_base;

    assign matched   = valid && (entry_reg.vbase == ctrl.key_vb)
                             && (entry_reg.len == ctrl.key_len);
    assign shift_out = shift_in | matched;
    assign entry_out = entry_reg;

    always_comb
    begin
        priority if (load)
        begin
            entry_next = ctrl.new_entry;
        end
        else if (ctrl.shift_en && shift_out)
        begin
            entry_next = neighbor_in;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    // Offset into this range; the wrap of the subtraction gives the range test.
    always_comb
    begin
        from_base = ctrl.fwd ? entry_reg.vbase : entry_reg.pbase;
        off_next  = ctrl.lookup - from_base;
        hit_next  = valid && (off_next < entry_reg.len);
        to_next   = ctrl.fwd ? entry_reg.pbase : entry_reg.vbase;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctrl.capture)
        begin
            hit_reg <= hit_next;
            off_reg <= off_next;
            to_reg  <= to_next;
        end
    end

    // The earliest hitting cell wins.
    always_comb
    begin
        sel_out.found = sel_in.found | hit_reg;
        sel_out.to    = sel_in.found ? sel_in.to  : to_reg;
        sel_out.off   = sel_in.found ? sel_in.off : off_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/page_range_address_translator.sv =====
// Top level of the page range address translator: sequencer, count and cell row.
//
//   Channel | Dir | Payload                                   | Transfer when
//   req     | in  | action, virt_addr, phys_addr, length      | req.valid & req.ready
//   rsp     | out | result_addr, hit, status                  | rsp.valid & rsp.ready
//
// An unmap removes the matching entries one per cycle as the cell row shifts left.
// Translate time is set by the per-cell offset register and the priority chain.
// Reset clears the entry count, the sequencer and the response valid; the cells
// hold no reset state. A stalled response holds the sequencer before it writes
// the next result; one request is taken while the last response still waits.
`default_nettype none

module page_range_address_translator (
    input wire logic clk,
    input wire logic rst_n,
    prat_in_if.sink    req,
    prat_out_if.source rsp
);
    import prat_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SEL  = 2'd2;

    logic [1:0] state_reg, state_next;
    count_t     cnt_reg, cnt_next;
    logic       removed_reg, removed_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg, out_item_next;

    // Operation registers, loaded when a request is taken; bases and length are page aligned.
    logic [1:0] op_action_reg;
    addr_t      op_vb_reg;
    addr_t      op_pb_reg;
    addr_t      op_rl_reg;
    addr_t      op_lookup_reg;

    logic       req_fire;
    logic       res_ready;
    logic       out_load;
    logic       do_map_write;
    logic       any_match;
    addr_t      xlat_addr;

    cell_ctrl_t ctrl;
    logic   [TABLE_ENTRIES-1:0] cell_valid;
    logic   [TABLE_ENTRIES-1:0] cell_load;
    entry_t [TABLE_ENTRIES-1:0] cell_entry;
    logic   [TABLE_ENTRIES:0]   shift_chain;
    sel_t   [TABLE_ENTRIES:0]   sel_chain;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign res_ready = !out_valid_reg || rsp.ready;

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_action_reg <= req.payload.action;
            op_vb_reg     <= req.payload.virt_addr & PAGE_MASK;
            op_pb_reg     <= req.payload.phys_addr & PAGE_MASK;
            op_rl_reg     <= (req.payload.length + PAGE_OFFS_MASK) & PAGE_MASK;
            op_lookup_reg <= (req.payload.action == ACT_V2P) ? req.payload.virt_addr
                                                             : req.payload.phys_addr;
        end
    end

    // Control broadcast to the cell row.
    always_comb
    begin
        ctrl.shift_en        = (state_reg == S_EXEC) && (op_action_reg == ACT_UNMAP);
        ctrl.capture         = (state_reg == S_EXEC);
        ctrl.fwd             = (op_action_reg == ACT_V2P);
        ctrl.lookup          = op_lookup_reg;
        ctrl.key_vb          = op_vb_reg;
        ctrl.key_len         = op_rl_reg;
        ctrl.new_entry.vbase = op_vb_reg;
        ctrl.new_entry.pbase = op_pb_reg;
        ctrl.new_entry.len   = op_rl_reg;
    end

    assign do_map_write = (state_reg == S_EXEC) && (op_action_reg == ACT_MAP)
                          && res_ready && (cnt_reg < count_t'(TABLE_ENTRIES));

    assign shift_chain[0] = 1'b0;
    assign sel_chain[0]   = '0;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        entry_t neighbor;

        assign cell_valid[i] = (count_t'(i) < cnt_reg);
        assign cell_load[i]  = do_map_write && (cnt_reg == count_t'(i));

        if (i == TABLE_ENTRIES - 1)
        begin : g_last
            assign neighbor = '0;
        end
        else
        begin : g_mid
            assign neighbor = cell_entry[i+1];
        end

        prat_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .valid       (cell_valid[i]),
            .load        (cell_load[i]),
            .neighbor_in (neighbor),
            .entry_out   (cell_entry[i]),
            .shift_in    (shift_chain[i]),
            .shift_out   (shift_chain[i+1]),
            .sel_in      (sel_chain[i]),
            .sel_out     (sel_chain[i+1])
        );
    end

    // In an unmap, a match anywhere in the valid part of the row removes the first matching entry this cycle.
    assign any_match = shift_chain[TABLE_ENTRIES];
    assign xlat_addr = sel_chain[TABLE_ENTRIES].to + sel_chain[TABLE_ENTRIES].off;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        removed_next   = removed_reg;
        out_item_next  = out_item_reg;
        out_load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next   = S_EXEC;
                    removed_next = 1'b0;
                end
            end
            S_EXEC:
            begin
                unique case (op_action_reg)
                    ACT_MAP:
                    begin
                        if (res_ready)
                        begin
                            out_load                  = 1'b1;
                            out_item_next.result_addr = op_vb_reg;
                            out_item_next.hit         = 1'b0;
                            if (do_map_write)
                            begin
                                cnt_next             = cnt_reg + count_t'(1);
                                out_item_next.status = ST_OK;
                            end
                            else
                            begin
                                out_item_next.status = ST_FULL;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    ACT_UNMAP:
                    begin
                        if (any_match)
                        begin
                            cnt_next     = cnt_reg - count_t'(1);
                            removed_next = 1'b1;
                        end
                        else if (res_ready)
                        begin
                            out_load                  = 1'b1;
                            out_item_next.result_addr = '0;
                            out_item_next.hit         = removed_reg;
                            out_item_next.status      = removed_reg ? ST_OK : ST_NOT_FOUND;
                            state_next                = S_IDLE;
                        end
                    end
                    ACT_V2P, ACT_P2V:
                    begin
                        state_next = S_SEL;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SEL:
            begin
                if (res_ready)
                begin
                    out_load                  = 1'b1;
                    out_item_next.result_addr = sel_chain[TABLE_ENTRIES].found
                                                ? xlat_addr : op_lookup_reg;
                    out_item_next.hit         = sel_chain[TABLE_ENTRIES].found;
                    out_item_next.status      = ST_OK;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            removed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            removed_reg   <= removed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    // The entry count never exceeds the size of the cell row.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= count_t'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    // Each compaction step removes exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && op_action_reg == ACT_UNMAP && any_match)
        |=> (cnt_reg == $past(cnt_reg) - count_t'(1)))
        else $error("unmap step did not remove one entry");

    // A map on a full table reports full and leaves the count alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && op_action_reg == ACT_MAP && res_ready
         && cnt_reg == count_t'(TABLE_ENTRIES))
        |=> (rsp.payload.status == ST_FULL && $stable(cnt_reg)))
        else $error("map on full table misreported");

    // Writing a result always returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("result written without returning to idle");

endmodule

`default_nettype wire
